// ===== sv/atrp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrp_pkg: shared widths, register indexes and the arctangent table
// Constants for the tilt angle pipeline (calibration, square root, CORDIC).
// ----------------------------------------------------------------------------
package atrp_pkg;

  localparam int AxisWidth  = 16;
  localparam int NumWidth   = 17;  // numerator may be -(-32768)
  localparam int SqHalfW    = 31;  // one square, unsigned
  localparam int SqWidth    = 32;  // sum of two squares
  localparam int RadWidth   = 48;  // sum of squares scaled by 2^16
  localparam int RootWidth  = 24;
  localparam int RemWidth   = 26;
  localparam int SqrtStages = RadWidth / 2;
  localparam int VecWidth   = 28;
  localparam int AngWidth   = 33;
  localparam int TableLen   = 24;
  localparam int TableFrac  = 24;
  localparam int CfgIdxW    = 2;

  localparam logic [CfgIdxW-1:0] CfgOffsetX = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgOffsetY = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgOffsetZ = 2'd2;

  // atan(2^-i) in degrees, scaled by 2^24
  localparam logic [30:0] AtanDegQ24 [TableLen] = '{
    31'd754974720, 31'd445687602, 31'd235489088, 31'd119537938,
    31'd60000934,  31'd30029717,  31'd15018523,  31'd7509720,
    31'd3754917,   31'd1877466,   31'd938734,    31'd469367,
    31'd234684,    31'd117342,    31'd58671,     31'd29335,
    31'd14668,     31'd7334,      31'd3667,      31'd1833,
    31'd917,       31'd458,       31'd229,       31'd115
  };

  // add a calibration offset and clamp to 16 signed bits
  function automatic logic signed [AxisWidth-1:0] sat_add16(
    input logic signed [AxisWidth-1:0] a,
    input logic signed [AxisWidth-1:0] b
  );
    logic signed [AxisWidth:0] s;
    s = {a[AxisWidth-1], a} + {b[AxisWidth-1], b};
    if (s[AxisWidth] != s[AxisWidth-1]) begin
      sat_add16 = s[AxisWidth] ? 16'sh8000 : 16'sh7fff;
    end else begin
      sat_add16 = s[AxisWidth-1:0];
    end
  endfunction

endpackage

// ===== sv/atrp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrp_if: channel interfaces for the tilt block
// Sample input, angle output and offset register write channels.
// ----------------------------------------------------------------------------
interface atrp_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  modport source (output valid, accel_x, accel_y, accel_z, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface atrp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_deg;
  logic signed [15:0] pitch_deg;
  modport source (output valid, roll_deg, pitch_deg, input ready);
  modport sink   (input valid, roll_deg, pitch_deg, output ready);
endinterface

interface atrp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

// ===== sv/atrp_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrp_sqrt: pipelined floor square root
// Takes sum of squares times 2^16, one root bit per stage; carries numerator.
// ----------------------------------------------------------------------------
module atrp_sqrt
  import atrp_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic        [SqWidth-1:0]   sq_i,
  input  logic signed [NumWidth-1:0]  num_i,
  output logic        [RootWidth-1:0] root_o,
  output logic signed [NumWidth-1:0]  num_o
);

  logic        [RemWidth-1:0]  rem_q  [SqrtStages];
  logic        [RootWidth-1:0] root_q [SqrtStages];
  logic        [RadWidth-1:0]  rad_q  [SqrtStages];
  logic signed [NumWidth-1:0]  num_q  [SqrtStages];

  for (genvar k = 0; k < SqrtStages; k++) begin : g_stage
    logic        [RemWidth-1:0]  rem_c;
    logic        [RootWidth-1:0] root_c;
    logic        [RadWidth-1:0]  rad_c;
    logic signed [NumWidth-1:0]  num_c;
    logic        [RemWidth+1:0]  cat;
    logic        [RemWidth+1:0]  trial;

    if (k == 0) begin : g_first
      assign rem_c  = '0;
      assign root_c = '0;
      assign rad_c  = {sq_i, 16'h0000};
      assign num_c  = num_i;
    end else begin : g_next
      assign rem_c  = rem_q[k-1];
      assign root_c = root_q[k-1];
      assign rad_c  = rad_q[k-1];
      assign num_c  = num_q[k-1];
    end

    assign cat   = {rem_c, rad_c[RadWidth-1 -: 2]};
    assign trial = {2'b00, root_c, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (cat >= trial) begin
          rem_q[k]  <= RemWidth'(cat - trial);
          root_q[k] <= {root_c[RootWidth-2:0], 1'b1};
        end else begin
          rem_q[k]  <= RemWidth'(cat);
          root_q[k] <= {root_c[RootWidth-2:0], 1'b0};
        end
        rad_q[k] <= {rad_c[RadWidth-3:0], 2'b00};
        num_q[k] <= num_c;
      end
    end
  end

  assign root_o = root_q[SqrtStages-1];
  assign num_o  = num_q[SqrtStages-1];

endmodule

// ===== sv/atrp_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atrp_cordic: pipelined vectoring CORDIC, one rotation per stage
// Gives atan(num / den) in degrees, rounded and clamped to 16 bits.
// ----------------------------------------------------------------------------
module atrp_cordic
  import atrp_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 8,
  parameter int CORDIC_STEPS    = 16
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic        [RootWidth-1:0] den_i,
  input  logic signed [NumWidth-1:0]  num_i,
  output logic signed [AxisWidth-1:0] angle_o
);

  localparam int Shift = TableFrac - ANGLE_FRAC_BITS;
  localparam logic signed [AngWidth-1:0] Half  = AngWidth'(1) <<< (Shift - 1);
  localparam logic signed [AngWidth-1:0] Ninety = AngWidth'(90) <<< ANGLE_FRAC_BITS;

  logic signed [VecWidth-1:0] vx_q  [CORDIC_STEPS];
  logic signed [VecWidth-1:0] vy_q  [CORDIC_STEPS];
  logic signed [AngWidth-1:0] ang_q [CORDIC_STEPS];
  logic                       zero_q [CORDIC_STEPS];
  logic                       pos_q  [CORDIC_STEPS];
  logic                       neg_q  [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [VecWidth-1:0] cx, cy, dx, dy;
    logic signed [AngWidth-1:0] ca, step;
    logic                       cz, cp, cn;

    if (i == 0) begin : g_first
      assign cx = VecWidth'(signed'({1'b0, den_i}));
      assign cy = VecWidth'(signed'({num_i, 8'h00}));
      assign ca = '0;
      assign cz = (den_i == '0);
      assign cp = !num_i[NumWidth-1] && (num_i != '0);
      assign cn = num_i[NumWidth-1];
    end else begin : g_next
      assign cx = vx_q[i-1];
      assign cy = vy_q[i-1];
      assign ca = ang_q[i-1];
      assign cz = zero_q[i-1];
      assign cp = pos_q[i-1];
      assign cn = neg_q[i-1];
    end

    assign dx   = cy >>> i;
    assign dy   = cx >>> i;
    assign step = AngWidth'(signed'({1'b0, AtanDegQ24[i]}));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!cy[VecWidth-1]) begin
          vx_q[i]  <= cx + dx;
          vy_q[i]  <= cy - dy;
          ang_q[i] <= ca + step;
        end else begin
          vx_q[i]  <= cx - dx;
          vy_q[i]  <= cy + dy;
          ang_q[i] <= ca - step;
        end
        zero_q[i] <= cz;
        pos_q[i]  <= cp;
        neg_q[i]  <= cn;
      end
    end
  end

  logic signed [AngWidth-1:0] rnd;
  logic signed [AngWidth-1:0] sel;

  always_comb begin
    rnd = (ang_q[CORDIC_STEPS-1] + Half) >>> Shift;
    if (zero_q[CORDIC_STEPS-1]) begin
      if (pos_q[CORDIC_STEPS-1]) begin
        sel = Ninety;
      end else if (neg_q[CORDIC_STEPS-1]) begin
        sel = -Ninety;
      end else begin
        sel = '0;
      end
    end else begin
      sel = rnd;
    end
    if (sel > AngWidth'(32767)) begin
      angle_o = 16'sh7fff;
    end else if (sel < -AngWidth'(32768)) begin
      angle_o = 16'sh8000;
    end else begin
      angle_o = sel[AxisWidth-1:0];
    end
  end

endmodule

// ===== sv/accel_tilt_roll_pitch.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_tilt_roll_pitch: roll and pitch from one calibrated 3-axis sample
// Two lanes (roll, pitch), each a square root pipeline and a CORDIC, merged
// into one output register.
//
//   channel  dir  payload                      accepted when
//   in_i     in   accel_x, accel_y, accel_z    valid && ready
//   out_o    out  roll_deg, pitch_deg          valid && ready
//   cfg_i    in   index, wdata (offsets 0..2)  valid && ready (always ready)
//
// One item per cycle while the output is not stalled. Stages in order: calibrate,
// square, sum, 24 square root stages, one stage per CORDIC rotation, output.
// Reset clears offsets and valid bits only. A stalled output holds the whole
// pipeline in place; in_i.ready follows the output register's state.
// ----------------------------------------------------------------------------
module accel_tilt_roll_pitch
  import atrp_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 8,
  parameter int CORDIC_STEPS    = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  atrp_in_if.sink    in_i,
  atrp_out_if.source out_o,
  atrp_cfg_if.sink   cfg_i
);

  localparam int Lat = 3 + SqrtStages + CORDIC_STEPS;

  logic signed [AxisWidth-1:0] off_x_q, off_y_q, off_z_q;
  logic [Lat-1:0]              valid_q;
  logic                        out_valid_q;
  logic                        en;

  assign en          = !out_valid_q || out_o.ready;
  assign in_i.ready  = en;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_x_q <= '0;
      off_y_q <= '0;
      off_z_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgOffsetX: off_x_q <= cfg_i.wdata;
        CfgOffsetY: off_y_q <= cfg_i.wdata;
        CfgOffsetZ: off_z_q <= cfg_i.wdata;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      valid_q     <= {valid_q[Lat-2:0], in_i.valid};
      out_valid_q <= valid_q[Lat-1];
    end
  end

  // calibrate, square, sum
  logic signed [AxisWidth-1:0] x_q, y_q, z_q;
  logic        [SqHalfW-1:0]   xx_q, yy_q, zz_q;
  logic signed [NumWidth-1:0]  nr_b_q, np_b_q, nr_c_q, np_c_q;
  logic        [SqWidth-1:0]   sqr_q, sqp_q;
  logic signed [2*AxisWidth-1:0] px, py, pz;

  assign px = x_q * x_q;
  assign py = y_q * y_q;
  assign pz = z_q * z_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q    <= sat_add16(in_i.accel_x, off_x_q);
      y_q    <= sat_add16(in_i.accel_y, off_y_q);
      z_q    <= sat_add16(in_i.accel_z, off_z_q);
      xx_q   <= px[SqHalfW-1:0];
      yy_q   <= py[SqHalfW-1:0];
      zz_q   <= pz[SqHalfW-1:0];
      nr_b_q <= NumWidth'(y_q);
      np_b_q <= -NumWidth'(x_q);
      sqr_q  <= SqWidth'(xx_q) + SqWidth'(zz_q);
      sqp_q  <= SqWidth'(yy_q) + SqWidth'(zz_q);
      nr_c_q <= nr_b_q;
      np_c_q <= np_b_q;
    end
  end

  // lanes: 0 = roll, 1 = pitch
  logic        [SqWidth-1:0]   lane_sq   [2];
  logic signed [NumWidth-1:0]  lane_num  [2];
  logic        [RootWidth-1:0] lane_den  [2];
  logic signed [NumWidth-1:0]  lane_numd [2];
  logic signed [AxisWidth-1:0] lane_ang  [2];

  assign lane_sq[0]  = sqr_q;
  assign lane_sq[1]  = sqp_q;
  assign lane_num[0] = nr_c_q;
  assign lane_num[1] = np_c_q;

  for (genvar l = 0; l < 2; l++) begin : g_lane
    atrp_sqrt u_sqrt (
      .clk_i  (clk_i),
      .en_i   (en),
      .sq_i   (lane_sq[l]),
      .num_i  (lane_num[l]),
      .root_o (lane_den[l]),
      .num_o  (lane_numd[l])
    );

    atrp_cordic #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
      .CORDIC_STEPS    (CORDIC_STEPS)
    ) u_cordic (
      .clk_i   (clk_i),
      .en_i    (en),
      .den_i   (lane_den[l]),
      .num_i   (lane_numd[l]),
      .angle_o (lane_ang[l])
    );
  end

  // merge both lanes into the output register
  logic signed [AxisWidth-1:0] roll_q, pitch_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_q  <= lane_ang[0];
      pitch_q <= lane_ang[1];
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.roll_deg  = roll_q;
  assign out_o.pitch_deg = pitch_q;

  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> valid_q[0])
    else $error("accepted item did not enter the pipeline");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(valid_q) && $stable(roll_q) && $stable(pitch_q))
    else $error("pipeline moved during an output stall");

  a_cfg_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_i.valid && cfg_i.index == CfgOffsetX |=> off_x_q == $past(cfg_i.wdata))
    else $error("offset_x write lost");

endmodule
